FILE: hw/rtl/famr_pkg.sv
`default_nettype none
package famr_pkg;

  localparam int IN_W = 16;
  localparam int RAW_NUM_W = 33;
  localparam int RAW_DEN_W = 32;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W = 6;

  localparam logic [1:0] CMD_MUL = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULN,
    S_MULD,
    S_GCD,
    S_GSTEP,
    S_DIV,
    S_KA,
    S_KB,
    S_SA,
    S_SB,
    S_RD,
    S_QN,
    S_QD,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/famr_if.sv
`default_nettype none
interface famr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] num_a;
  logic [15:0] den_a;
  logic [15:0] num_b;
  logic [15:0] den_b;
  modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

interface famr_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] raw_num;
  logic [31:0] raw_den;
  logic [31:0] scaled_a;
  logic [31:0] scaled_b;
  logic [32:0] red_num;
  logic [31:0] red_den;
  logic        is_whole;
  logic        bad_input;
  modport source (output valid, raw_num, raw_den, scaled_a, scaled_b, red_num, red_den,
                  is_whole, bad_input, input ready);
  modport sink (input valid, raw_num, raw_den, scaled_a, scaled_b, red_num, red_den,
                is_whole, bad_input, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fraction_add_mul_reduce_unit.sv
`default_nettype none
// channel  role  payload
// in_ch    sink  cmd, num_a, den_a, num_b, den_b
// out_ch   src   raw_num, raw_den, scaled_a, scaled_b, red_num, red_den, is_whole, bad_input
//
// one transaction at a time; in_ch.ready is high only while idle and out of reset
// a shared 16x16 multiplier and a one-bit-per-cycle restoring divider do all work;
// gcd is euclid on that divider; a zero denominator goes straight to the output
// reduce runs one gcd; multiply forms both products first; add runs a gcd of the
// denominators and scales both fractions before the final gcd
// reset clears the sequencer and the output valid; a stalled output holds the block
module fraction_add_mul_reduce_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  famr_in_if.sink   in_ch,
  famr_out_if.source out_ch
);

  localparam int EW = (OPERAND_WIDTH > famr_pkg::IN_W) ? famr_pkg::IN_W : OPERAND_WIDTH;
  localparam logic [15:0] OP_MASK = 16'((33'd1 << EW) - 33'd1);

  famr_pkg::state_t state, state_next, ret;

  logic [15:0] na, da, nb, db, ka, kb;
  logic [32:0] rn, qn, gx, gy, dq, rem, dv;
  logic [31:0] rd, sa, sb, qd;
  logic        whole, bad, phase;
  logic [famr_pkg::CNT_W-1:0] cnt;
  logic        out_valid;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [33:0] dtmp;
  logic        dge;
  logic [15:0] ina, ida, inb, idb;
  logic        in_bad;

  assign ina = in_ch.num_a & OP_MASK;
  assign ida = in_ch.den_a & OP_MASK;
  assign inb = in_ch.num_b & OP_MASK;
  assign idb = in_ch.den_b & OP_MASK;
  assign in_bad = (ida == 16'd0) ||
                  ((in_ch.cmd == famr_pkg::CMD_MUL || in_ch.cmd == famr_pkg::CMD_ADD) &&
                   idb == 16'd0);

  assign in_ch.ready = (state == famr_pkg::S_IDLE) && !rst;

  always_comb begin
    mul_a = na;
    mul_b = nb;
    unique case (state)
      famr_pkg::S_MULD: begin
        mul_a = da;
        mul_b = db;
      end
      famr_pkg::S_SA: begin
        mul_a = na;
        mul_b = kb;
      end
      famr_pkg::S_SB: begin
        mul_a = nb;
        mul_b = ka;
      end
      famr_pkg::S_RD: begin
        mul_a = da;
        mul_b = kb;
      end
      default: begin
        mul_a = na;
        mul_b = nb;
      end
    endcase
  end

  assign prod = {16'd0, mul_a} * {16'd0, mul_b};
  assign dtmp = {rem, dq[32]};
  assign dge  = dtmp >= {1'b0, dv};

  always_comb begin
    state_next = state;
    unique case (state)
      famr_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (in_bad) begin
            state_next = famr_pkg::S_OUT;
          end else if (in_ch.cmd == famr_pkg::CMD_MUL) begin
            state_next = famr_pkg::S_MULN;
          end else begin
            state_next = famr_pkg::S_GCD;
          end
        end
      end
      famr_pkg::S_MULN:  state_next = famr_pkg::S_MULD;
      famr_pkg::S_MULD:  state_next = famr_pkg::S_GCD;
      famr_pkg::S_GCD:   state_next = famr_pkg::S_DIV;
      famr_pkg::S_GSTEP: state_next = famr_pkg::S_GCD;
      famr_pkg::S_DIV: begin
        if (cnt == famr_pkg::CNT_W'(1)) begin
          state_next = ret;
        end
      end
      famr_pkg::S_KA:    state_next = famr_pkg::S_DIV;
      famr_pkg::S_KB:    state_next = famr_pkg::S_SA;
      famr_pkg::S_SA:    state_next = famr_pkg::S_SB;
      famr_pkg::S_SB:    state_next = famr_pkg::S_RD;
      famr_pkg::S_RD:    state_next = famr_pkg::S_GCD;
      famr_pkg::S_QN:    state_next = famr_pkg::S_DIV;
      famr_pkg::S_QD:    state_next = famr_pkg::S_OUT;
      famr_pkg::S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = famr_pkg::S_IDLE;
        end
      end
      default: state_next = famr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= famr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == famr_pkg::S_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      famr_pkg::S_IDLE: begin
        na <= ina;
        da <= ida;
        nb <= inb;
        db <= idb;
        bad <= in_bad;
        sa <= '0;
        sb <= '0;
        qn <= '0;
        qd <= '0;
        whole <= 1'b0;
        if (in_ch.cmd == famr_pkg::CMD_ADD) begin
          phase <= 1'b0;
          rn <= '0;
          rd <= '0;
          gx <= {17'd0, ida};
          gy <= {17'd0, idb};
        end else begin
          phase <= 1'b1;
          rn <= in_bad ? 33'd0 : {17'd0, ina};
          rd <= in_bad ? 32'd0 : {16'd0, ida};
          gx <= {17'd0, ina};
          gy <= {17'd0, ida};
        end
      end
      famr_pkg::S_MULN: rn <= {1'b0, prod};
      famr_pkg::S_MULD: begin
        rd <= prod;
        gx <= rn;
        gy <= {1'b0, prod};
      end
      famr_pkg::S_GCD: begin
        dq <= (gy == '0) ? (phase ? rn : {17'd0, da}) : gx;
        dv <= (gy == '0) ? gx : gy;
        rem <= '0;
        cnt <= famr_pkg::CNT_W'(famr_pkg::DIV_STEPS);
        ret <= (gy == '0) ? (phase ? famr_pkg::S_QN : famr_pkg::S_KA) : famr_pkg::S_GSTEP;
      end
      famr_pkg::S_GSTEP: begin
        gx <= gy;
        gy <= rem;
      end
      famr_pkg::S_DIV: begin
        rem <= dge ? 33'(dtmp - {1'b0, dv}) : dtmp[32:0];
        dq <= {dq[31:0], dge};
        cnt <= cnt - famr_pkg::CNT_W'(1);
      end
      famr_pkg::S_KA: begin
        ka <= dq[15:0];
        dq <= {17'd0, db};
        dv <= gx;
        rem <= '0;
        cnt <= famr_pkg::CNT_W'(famr_pkg::DIV_STEPS);
        ret <= famr_pkg::S_KB;
      end
      famr_pkg::S_KB: kb <= dq[15:0];
      famr_pkg::S_SA: sa <= prod;
      famr_pkg::S_SB: sb <= prod;
      famr_pkg::S_RD: begin
        rd <= prod;
        rn <= {1'b0, sa} + {1'b0, sb};
        gx <= {1'b0, sa} + {1'b0, sb};
        gy <= {1'b0, prod};
        phase <= 1'b1;
      end
      famr_pkg::S_QN: begin
        qn <= dq;
        dq <= {1'b0, rd};
        dv <= gx;
        rem <= '0;
        cnt <= famr_pkg::CNT_W'(famr_pkg::DIV_STEPS);
        ret <= famr_pkg::S_QD;
      end
      famr_pkg::S_QD: begin
        qd <= dq[31:0];
        whole <= (gx == {1'b0, rd});
      end
      famr_pkg::S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_ch.raw_num <= rn;
          out_ch.raw_den <= rd;
          out_ch.scaled_a <= sa;
          out_ch.scaled_b <= sb;
          out_ch.red_num <= qn;
          out_ch.red_den <= qd;
          out_ch.is_whole <= whole;
          out_ch.bad_input <= bad;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid;

endmodule
`default_nettype wire
